// ===== hw/rtl/ffe_pkg.sv =====
package ffe_pkg;

    typedef enum logic [2:0] {
        PH_MATCH = 3'd0,
        PH_SKIP  = 3'd1,
        PH_VALUE = 3'd2,
        PH_DONE  = 3'd3
    } t_phase;

    typedef struct packed {
        logic [63:0] field_name;
        logic [3:0]  name_length;
        logic [7:0]  max_value_length;
    } t_cfg;

    typedef struct packed {
        logic [7:0] value_byte;
        logic       byte_valid;
        logic       found;
        logic       last;
    } t_result;

    localparam logic [1:0] CFG_FIELD_NAME       = 2'd0;
    localparam logic [1:0] CFG_NAME_LENGTH      = 2'd1;
    localparam logic [1:0] CFG_MAX_VALUE_LENGTH = 2'd2;

endpackage

// ===== hw/rtl/ffe_core.sv =====
module ffe_core
    import ffe_pkg::*;
#(
    parameter int NAME_MAX_CHARS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_byte,
    input  logic             i_eob,
    input  t_cfg             i_cfg,
    output t_result [1:0]    o_res,
    output logic [1:0]       o_res_n
);

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    localparam logic [1:0] ESC_NONE = 2'd0;
    localparam logic [1:0] ESC_ONE  = 2'd1;
    localparam logic [1:0] ESC_TWO  = 2'd2;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_match_count, n_match_count;
    logic [1:0]  r_escape, n_escape;
    logic [7:0]  r_held, n_held;
    logic [7:0]  r_emitted, n_emitted;

    logic        is_end, fin, va_en;
    logic [3:0]  nl;
    logic [7:0]  want;
    logic [1:0]  esc_a;
    logic [7:0]  held_a;
    logic        a_emit;
    logic [7:0]  a_byte;
    logic [1:0]  c_n, e_n;
    logic [7:0]  c0, c1;
    logic        ok0, ok1;
    t_phase      m_phase;
    logic [3:0]  m_match_count;

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
        return r;
    endfunction

    function automatic logic [7:0] decode_pair(input logic [7:0] a, input logic [7:0] b);
        logic [4:0] ha;
        logic [4:0] hb;
        logic [7:0] r;
        ha = hex_val(a);
        hb = hex_val(b);
        if (a == CH_SPACE || (a >= 8'd9 && a <= 8'd13) || a == CH_PLUS) begin
            r = hb[4] ? 8'd0 : {4'd0, hb[3:0]};
        end else if (a == CH_MINUS) begin
            r = hb[4] ? 8'd0 : 8'(8'd0 - {4'd0, hb[3:0]});
        end else if (ha[4]) begin
            r = 8'd0;
        end else if (hb[4]) begin
            r = {4'd0, ha[3:0]};
        end else begin
            r = {ha[3:0], hb[3:0]};
        end
        return r;
    endfunction

    function automatic logic [7:0] plain(input logic [7:0] c);
        return (c == CH_PLUS) ? CH_SPACE : c;
    endfunction

    assign is_end = (i_byte == 8'd0) || i_eob;
    assign fin    = is_end || (i_byte == CH_AMP);
    assign va_en  = (i_byte != 8'd0) && (i_byte != CH_AMP);
    assign nl     = (i_cfg.name_length > 4'(NAME_MAX_CHARS)) ? 4'(NAME_MAX_CHARS)
                                                              : i_cfg.name_length;
    assign want   = i_cfg.field_name[{r_match_count[2:0], 3'b000} +: 8];

    // value decode: one byte step, then flush of a short escape at value end, then the length cap
    always_comb begin
        esc_a  = r_escape;
        held_a = r_held;
        a_emit = 1'b0;
        a_byte = 8'd0;
        if (va_en) begin
            if (r_escape == ESC_ONE) begin
                held_a = i_byte;
                esc_a  = ESC_TWO;
            end else if (r_escape == ESC_TWO) begin
                esc_a  = ESC_NONE;
                a_emit = 1'b1;
                a_byte = decode_pair(r_held, i_byte);
            end else if (i_byte == CH_PCT) begin
                esc_a = ESC_ONE;
            end else begin
                a_emit = 1'b1;
                a_byte = plain(i_byte);
            end
        end
        c_n = 2'd0;
        c0  = 8'd0;
        c1  = 8'd0;
        if (a_emit) begin
            c_n = 2'd1;
            c0  = a_byte;
        end else if (fin) begin
            if (esc_a == ESC_ONE) begin
                c_n = 2'd1;
                c0  = CH_PCT;
            end else if (esc_a == ESC_TWO) begin
                c_n = 2'd2;
                c0  = CH_PCT;
                c1  = plain(held_a);
            end
        end
        ok0 = {1'b0, r_emitted} < {1'b0, i_cfg.max_value_length};
        ok1 = ({1'b0, r_emitted} + 9'd1) < {1'b0, i_cfg.max_value_length};
        if (c_n == 2'd0) e_n = 2'd0;
        else if (c_n == 2'd1) e_n = ok0 ? 2'd1 : 2'd0;
        else if (ok1) e_n = 2'd2;
        else e_n = ok0 ? 2'd1 : 2'd0;
    end

    // name matching at field start
    always_comb begin
        m_phase       = r_phase;
        m_match_count = r_match_count;
        if (i_byte != 8'd0) begin
            if (r_phase == PH_SKIP) begin
                if (i_byte == CH_AMP) begin
                    m_phase       = PH_MATCH;
                    m_match_count = 4'd0;
                end
            end else if (r_match_count < nl) begin
                if (want == i_byte && i_byte != CH_AMP) begin
                    m_match_count = r_match_count + 4'd1;
                end else if (i_byte == CH_AMP) begin
                    m_match_count = 4'd0;
                end else begin
                    m_phase = PH_SKIP;
                end
            end else begin
                if (i_byte == CH_EQ) begin
                    m_phase = PH_VALUE;
                end else if (i_byte == CH_AMP) begin
                    m_match_count = 4'd0;
                end else begin
                    m_phase = PH_SKIP;
                end
            end
        end
    end

    // next state
    always_comb begin
        n_phase       = r_phase;
        n_match_count = r_match_count;
        n_escape      = r_escape;
        n_held        = r_held;
        n_emitted     = r_emitted;
        if (i_accept) begin
            unique case (r_phase)
                PH_VALUE: begin
                    n_escape  = fin ? ESC_NONE : esc_a;
                    n_held    = held_a;
                    n_emitted = r_emitted + {6'd0, e_n};
                    if (fin) n_phase = PH_DONE;
                end
                PH_MATCH, PH_SKIP: begin
                    n_phase       = m_phase;
                    n_match_count = m_match_count;
                    if (m_phase == PH_VALUE) begin
                        n_escape  = ESC_NONE;
                        n_emitted = 8'd0;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
            if (is_end) begin
                n_phase       = PH_MATCH;
                n_match_count = 4'd0;
                n_escape      = ESC_NONE;
                n_held        = 8'd0;
                n_emitted     = 8'd0;
            end
        end
    end

    // results
    always_comb begin
        o_res_n = 2'd0;
        o_res   = '0;
        if (i_accept) begin
            unique case (r_phase)
                PH_VALUE: begin
                    o_res[0] = '{value_byte: c0, byte_valid: 1'b1, found: 1'b1, last: 1'b0};
                    o_res[1] = '{value_byte: c1, byte_valid: 1'b1, found: 1'b1, last: 1'b0};
                    o_res_n  = e_n;
                    if (fin) begin
                        if (e_n == 2'd0) begin
                            o_res[0] = '{value_byte: 8'd0, byte_valid: 1'b0, found: 1'b1,
                                         last: 1'b1};
                            o_res_n  = 2'd1;
                        end else if (e_n == 2'd1) begin
                            o_res[0].last = 1'b1;
                        end else begin
                            o_res[1].last = 1'b1;
                        end
                    end
                end
                PH_MATCH, PH_SKIP: begin
                    if (is_end) begin
                        o_res[0] = '{value_byte: 8'd0, byte_valid: 1'b0,
                                     found: (m_phase == PH_VALUE), last: 1'b1};
                        o_res_n  = 2'd1;
                    end
                end
                default: begin
                    o_res_n = 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_MATCH;
            r_match_count <= 4'd0;
            r_escape      <= ESC_NONE;
            r_held        <= 8'd0;
            r_emitted     <= 8'd0;
        end else begin
            r_phase       <= n_phase;
            r_match_count <= n_match_count;
            r_escape      <= n_escape;
            r_held        <= n_held;
            r_emitted     <= n_emitted;
        end
    end

endmodule

// ===== hw/rtl/ffe_out_fifo.sv =====
module ffe_out_fifo
    import ffe_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_result [1:0] i_push,
    input  logic [1:0]    i_push_n,
    input  logic          i_pop,
    output logic          o_valid,
    output t_result       o_head,
    output logic          o_room
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    t_result            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [PTR_W:0]     r_count, n_count;
    logic               pop_ok;
    logic [PTR_W-1:0]   wr_ptr1;

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign o_room  = (r_count <= (PTR_W+1)'(DEPTH - 2));
    assign pop_ok  = i_pop && o_valid;
    assign wr_ptr1 = r_wr_ptr + PTR_W'(1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + PTR_W'(i_push_n);
        n_rd_ptr = r_rd_ptr + PTR_W'(pop_ok);
        n_count  = r_count + (PTR_W+1)'(i_push_n) - (PTR_W+1)'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) r_mem[r_wr_ptr] <= i_push[0];
        if (i_push_n == 2'd2) r_mem[wr_ptr1] <= i_push[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== hw/rtl/form_field_extractor.sv =====
// each accepted body word is decoded combinationally into the registered output queue
// throughput: one body word per cycle while the output queue has room
// a body word that yields two result words pushes both into the output queue together
// the four-entry output queue takes a word while it has room for two results
// synchronous active-low reset returns to field start and restores register defaults
module form_field_extractor
    import ffe_pkg::*;
#(
    parameter int NAME_MAX_CHARS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // body_byte
    input  logic        i_s_tlast,   // end_of_body
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // value_byte
    output logic [1:0]  o_m_tuser,   // byte_valid, found
    output logic        o_m_tlast,   // last
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    t_cfg          r_cfg;
    logic          accept;
    t_result [1:0] res;
    logic [1:0]    res_n;
    t_result       head;
    logic          room;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = room;
    assign accept      = i_s_tvalid && room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.field_name       <= 64'd1684632435;
            r_cfg.name_length      <= 4'd4;
            r_cfg.max_value_length <= 8'd32;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FIELD_NAME:       r_cfg.field_name       <= i_cfg_data;
                CFG_NAME_LENGTH:      r_cfg.name_length      <= i_cfg_data[3:0];
                CFG_MAX_VALUE_LENGTH: r_cfg.max_value_length <= i_cfg_data[7:0];
                default:              r_cfg                  <= r_cfg;
            endcase
        end
    end

    ffe_core #(
        .NAME_MAX_CHARS(NAME_MAX_CHARS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_tdata),
        .i_eob    (i_s_tlast),
        .i_cfg    (r_cfg),
        .o_res    (res),
        .o_res_n  (res_n)
    );

    ffe_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (res),
        .i_push_n (res_n),
        .i_pop    (i_m_tready),
        .o_valid  (o_m_tvalid),
        .o_head   (head),
        .o_room   (room)
    );

    assign o_m_tdata = head.value_byte;
    assign o_m_tuser = {head.found, head.byte_valid};
    assign o_m_tlast = head.last;

endmodule

// ===== verif/form_field_extractor_tb.sv =====
`timescale 1ns / 1ps

module form_field_extractor_tb
    import ffe_pkg::*;
;

    localparam int         NAME_MAX_CHARS  = 8;
    localparam int         ITEMS_PER_PHASE = 100;
    localparam logic [7:0] CH_PLUS         = 8'h2B;
    localparam logic [7:0] CH_PCT          = 8'h25;
    localparam logic [7:0] CH_AMP          = 8'h26;
    localparam logic [7:0] CH_EQ           = 8'h3D;
    localparam logic [7:0] CH_SPACE        = 8'h20;
    localparam logic [7:0] CH_MINUS        = 8'h2D;
    localparam logic [7:0] CH_NUL          = 8'h00;

    class form_value_scoreboard;
        t_cfg       cfg;
        t_phase     phase;
        logic [3:0] match_count;
        logic [1:0] escape_pending;
        logic [7:0] held_char;
        logic [7:0] emitted_count;
        logic [7:0] decoded_q[$];
        t_result    expected_words[$];
        int         errors;
        int         results_seen;
        int         bodies_closed;
        int         bodies_found;

        function new();
            cfg.field_name       = 64'd1684632435;
            cfg.name_length      = 4'd4;
            cfg.max_value_length = 8'd32;
            errors               = 0;
            results_seen         = 0;
            bodies_closed        = 0;
            bodies_found         = 0;
            clear_body();
        endfunction

        function void clear_body();
            phase          = PH_MATCH;
            match_count    = 4'd0;
            escape_pending = 2'd0;
            held_char      = 8'd0;
            emitted_count  = 8'd0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [63:0] data);
            case (idx)
                CFG_FIELD_NAME:       cfg.field_name       = data;
                CFG_NAME_LENGTH:      cfg.name_length      = data[3:0];
                CFG_MAX_VALUE_LENGTH: cfg.max_value_length = data[7:0];
                default: ;
            endcase
        endfunction

        function int hex_val(logic [7:0] c);
            if (c >= "0" && c <= "9") return int'(c) - int'("0");
            if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
            if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
            return -1;
        endfunction

        // strtol-like read of a two-byte pair, kept to 8 bits
        function logic [7:0] decode_pair(logic [7:0] a, logic [7:0] b);
            int ha;
            int hb;
            ha = hex_val(a);
            hb = hex_val(b);
            if (a == CH_SPACE || (a >= 8'd9 && a <= 8'd13) || a == CH_PLUS)
                return (hb < 0) ? 8'd0 : 8'(hb);
            if (a == CH_MINUS) return (hb < 0) ? 8'd0 : 8'(256 - hb);
            if (ha < 0) return 8'd0;
            if (hb < 0) return 8'(ha);
            return 8'(ha * 16 + hb);
        endfunction

        function void emit_byte(logic [7:0] c);
            if (emitted_count < cfg.max_value_length && decoded_q.size() < 2) begin
                decoded_q.push_back(c);
                emitted_count = emitted_count + 8'd1;
            end
        endfunction

        function void value_char(logic [7:0] c);
            if (escape_pending == 2'd1) begin
                held_char      = c;
                escape_pending = 2'd2;
            end else if (escape_pending == 2'd2) begin
                escape_pending = 2'd0;
                emit_byte(decode_pair(held_char, c));
            end else if (c == CH_PCT) begin
                escape_pending = 2'd1;
            end else begin
                emit_byte((c == CH_PLUS) ? CH_SPACE : c);
            end
        endfunction

        function void flush_escape();
            if (escape_pending == 2'd1) begin
                emit_byte(CH_PCT);
            end else if (escape_pending == 2'd2) begin
                emit_byte(CH_PCT);
                emit_byte((held_char == CH_PLUS) ? CH_SPACE : held_char);
            end
            escape_pending = 2'd0;
        endfunction

        function void push_word(logic [7:0] v, logic vld, logic fnd, logic lst);
            t_result w;
            w.value_byte = vld ? v : 8'd0;
            w.byte_valid = vld;
            w.found      = fnd;
            w.last       = lst;
            expected_words.push_back(w);
            if (lst) begin
                bodies_closed++;
                if (fnd) bodies_found++;
            end
        endfunction

        function void note_body_word(logic [7:0] b, logic eob);
            logic       is_end;
            logic       fin;
            logic [3:0] nl;
            logic [7:0] want;
            is_end = (b == CH_NUL) || eob;
            nl     = (cfg.name_length > NAME_MAX_CHARS) ? 4'(NAME_MAX_CHARS) : cfg.name_length;
            decoded_q.delete();

            if (phase == PH_DONE) begin
                if (is_end) clear_body();
                return;
            end

            if (phase == PH_VALUE) begin
                fin = is_end;
                if (b == CH_AMP) fin = 1'b1;
                else if (b != CH_NUL) value_char(b);
                if (!fin) begin
                    foreach (decoded_q[k]) push_word(decoded_q[k], 1'b1, 1'b1, 1'b0);
                    return;
                end
                flush_escape();
                if (decoded_q.size() == 0) begin
                    push_word(8'd0, 1'b0, 1'b1, 1'b1);
                end else begin
                    foreach (decoded_q[k])
                        push_word(decoded_q[k], 1'b1, 1'b1, k == decoded_q.size() - 1);
                end
                if (is_end) clear_body();
                else phase = PH_DONE;
                return;
            end

            if (b != CH_NUL) begin
                if (phase == PH_SKIP) begin
                    if (b == CH_AMP) begin
                        phase       = PH_MATCH;
                        match_count = 4'd0;
                    end
                end else if (match_count < nl) begin
                    want = 8'(cfg.field_name >> (8 * match_count));
                    if (want == b && b != CH_AMP) match_count = match_count + 4'd1;
                    else if (b == CH_AMP) match_count = 4'd0;
                    else phase = PH_SKIP;
                end else begin
                    if (b == CH_EQ) begin
                        phase          = PH_VALUE;
                        escape_pending = 2'd0;
                        emitted_count  = 8'd0;
                    end else if (b == CH_AMP) begin
                        match_count = 4'd0;
                    end else begin
                        phase = PH_SKIP;
                    end
                end
            end

            if (is_end) begin
                push_word(8'd0, 1'b0, phase == PH_VALUE, 1'b1);
                clear_body();
            end
        endfunction

        function void check_value_word(t_result got);
            t_result want;
            results_seen++;
            if (expected_words.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word, expected none, actual %h", $time, got);
                return;
            end
            want = expected_words.pop_front();
            if (got.value_byte !== want.value_byte) begin
                errors++;
                $display("%0t: value_byte expected %h actual %h",
                         $time, want.value_byte, got.value_byte);
            end
            if (got.byte_valid !== want.byte_valid) begin
                errors++;
                $display("%0t: byte_valid expected %b actual %b",
                         $time, want.byte_valid, got.byte_valid);
            end
            if (got.found !== want.found) begin
                errors++;
                $display("%0t: found expected %b actual %b", $time, want.found, got.found);
            end
            if (got.last !== want.last) begin
                errors++;
                $display("%0t: last expected %b actual %b", $time, want.last, got.last);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;   // body_byte
    logic        i_s_tlast;   // end_of_body
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [7:0]  o_m_tdata;   // value_byte
    logic [1:0]  o_m_tuser;   // byte_valid, found
    logic        o_m_tlast;   // last
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    form_value_scoreboard sb;
    t_result              got;
    bit                   idle_on = 1'b1;
    int                   items_sent = 0;
    int                   settings_used = 1;
    logic [7:0]           body_q[$];
    bit                   body_flag;
    logic [63:0]          cur_name = 64'd1684632435;
    logic [3:0]           cur_len = 4'd4;

    form_field_extractor i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

    // output side: sample accepted words, then pick next ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.value_byte = o_m_tdata;
            got.byte_valid = o_m_tuser[0];
            got.found      = o_m_tuser[1];
            got.last       = o_m_tlast;
            sb.check_value_word(got);
        end
        i_m_tready <= !idle_on || ($urandom_range(99) >= 19);
    end

    function automatic int eff_len();
        return (cur_len > NAME_MAX_CHARS) ? NAME_MAX_CHARS : int'(cur_len);
    endfunction

    function automatic logic [7:0] text_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(33, 126));
        while (c == CH_AMP || c == CH_PCT || c == CH_PLUS);
        return c;
    endfunction

    function automatic logic [7:0] any_value_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255));
        while (c == CH_AMP);
        return c;
    endfunction

    function automatic logic [7:0] hex_digit();
        string digits;
        digits = "0123456789abcdefABCDEF";
        return 8'(digits[$urandom_range(0, 21)]);
    endfunction

    function automatic logic [7:0] non_hex();
        logic [7:0] c;
        do c = text_byte();
        while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F"));
        return c;
    endfunction

    function automatic logic [63:0] rand_name();
        logic [63:0] n;
        for (int i = 0; i < 8; i++) n[8*i +: 8] = 8'($urandom_range(97, 122));
        return n;
    endfunction

    function automatic void add_name(int count);
        for (int i = 0; i < count; i++) body_q.push_back(cur_name[8*i +: 8]);
    endfunction

    function automatic void add_value(int pieces);
        int r;
        for (int i = 0; i < pieces; i++) begin
            r = $urandom_range(0, 15);
            case (r)
                6: body_q.push_back(CH_PLUS);
                7: begin
                    body_q.push_back(CH_PCT);
                    body_q.push_back(hex_digit());
                    body_q.push_back(hex_digit());
                end
                8: begin
                    body_q.push_back(CH_PCT);
                    r = $urandom_range(8, 13);
                    body_q.push_back((r == 8) ? CH_SPACE : 8'(r));
                    body_q.push_back($urandom_range(1) ? hex_digit() : non_hex());
                end
                9: begin
                    body_q.push_back(CH_PCT);
                    body_q.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
                    body_q.push_back($urandom_range(1) ? hex_digit() : non_hex());
                end
                10: begin
                    body_q.push_back(CH_PCT);
                    body_q.push_back(non_hex());
                    body_q.push_back(any_value_byte());
                end
                11: body_q.push_back(any_value_byte());
                12: body_q.push_back(CH_EQ);
                default: body_q.push_back(text_byte());
            endcase
        end
        // short escape at the value end
        r = $urandom_range(0, 7);
        if (r == 0) begin
            body_q.push_back(CH_PCT);
        end else if (r == 1) begin
            body_q.push_back(CH_PCT);
            body_q.push_back($urandom_range(1) ? CH_PLUS : any_value_byte());
        end
    endfunction

    function automatic void build_body(int long_pieces);
        int nfields;
        int want_at;
        int kind;
        int r;
        body_q.delete();
        nfields = $urandom_range(1, 4);
        want_at = (long_pieces > 0) ? 0 : $urandom_range(0, nfields);
        if ($urandom_range(7) == 0) body_q.push_back(CH_AMP);
        for (int f = 0; f < nfields; f++) begin
            if (f > 0) body_q.push_back(CH_AMP);
            kind = (f == want_at) ? 0 : $urandom_range(1, 5);
            case (kind)
                1: begin
                    r = $urandom_range(1, 6);
                    for (int i = 0; i < r; i++) body_q.push_back(text_byte());
                    body_q.push_back(CH_EQ);
                    add_value($urandom_range(0, 6));
                end
                2: begin
                    add_name($urandom_range(0, eff_len()));
                    body_q.push_back(text_byte());
                    body_q.push_back(CH_EQ);
                    add_value($urandom_range(0, 6));
                end
                3: add_name(eff_len());
                4: ;
                default: begin
                    add_name(eff_len());
                    body_q.push_back(CH_EQ);
                    add_value((long_pieces > 0) ? long_pieces : $urandom_range(0, 10));
                end
            endcase
        end
        r = $urandom_range(0, 9);
        body_flag = 1'b1;
        if (r >= 7) begin
            body_q.push_back(CH_NUL);
            body_flag = (r == 9);
        end else if (r == 6) begin
            body_q.push_back(CH_AMP);
        end
        if (body_q.size() == 0) body_q.push_back(CH_NUL);
    endfunction

    function automatic void build_noise();
        body_q.delete();
        repeat ($urandom_range(1, 10)) body_q.push_back(8'($urandom_range(0, 255)));
        body_flag = 1'b1;
    endfunction

    task automatic send_word(input logic [7:0] b, input logic eob);
        while (idle_on && $urandom_range(99) < 19) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= eob;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_body_word(b, eob);
        items_sent++;
    endtask

    task automatic send_body();
        foreach (body_q[k]) send_word(body_q[k], (k == body_q.size() - 1) ? body_flag : 1'b0);
    endtask

    task automatic send_text(input string s, input bit zero_end);
        body_q.delete();
        for (int i = 0; i < s.len(); i++) body_q.push_back(8'(s[i]));
        body_flag = !zero_end;
        if (zero_end) body_q.push_back(CH_NUL);
        send_body();
    endtask

    task automatic drain(input int settle);
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_words.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic set_config(input logic [63:0] name, input logic [3:0] len,
                              input logic [7:0] maxlen);
        write_reg(CFG_FIELD_NAME, name);
        write_reg(CFG_NAME_LENGTH, {60'd0, len});
        write_reg(CFG_MAX_VALUE_LENGTH, {56'd0, maxlen});
        i_cfg_valid <= 1'b0;
        cur_name = name;
        cur_len  = len;
        settings_used++;
    endtask

    task automatic run_phase(input logic [63:0] name, input logic [3:0] len,
                             input logic [7:0] maxlen, input bit quiet, input int long_pieces);
        int start;
        drain(8);
        set_config(name, len, maxlen);
        idle_on = !quiet;
        start   = items_sent;
        if (long_pieces > 0) begin
            build_body(long_pieces);
            send_body();
        end
        while (items_sent - start < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 24) == 0) drain(0);
            if ($urandom_range(0, 9) == 0) build_noise();
            else build_body(0);
            send_body();
        end
        idle_on = 1'b1;
    endtask

    initial begin
        sb = new();
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= 8'd0;
        i_s_tlast   <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_FIELD_NAME;
        i_cfg_data  <= 64'd0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: held byte after a lone escape, bare escape, sign pair, tail
        send_text("ssid=%4", 1'b0);
        send_text("q&ssid=%", 1'b1);
        send_text("ssid=+%-f&x", 1'b0);
        body_q.delete();
        body_q.push_back(8'hFF);
        body_flag = 1'b1;
        send_body();

        run_phase(rand_name(), 4'd8, 8'd255, 1'b0, 0);
        run_phase(rand_name(), 4'd1, 8'd0, 1'b0, 0);
        run_phase(rand_name(), 4'd0, 8'd1, 1'b0, 0);
        run_phase(rand_name(), 4'd15, 8'd255, 1'b0, 270);
        run_phase(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 8'($urandom_range(0, 255)), 1'b1, 0);
        run_phase(64'h0000_0079_0078_266B, 4'd5, 8'd7, 1'b0, 0);
        run_phase(rand_name(), 4'($urandom_range(1, 8)), 8'($urandom_range(0, 255)), 1'b0, 0);
        run_phase(rand_name(), 4'($urandom_range(1, 8)), 8'($urandom_range(0, 255)), 1'b0, 0);
        run_phase(rand_name(), 4'($urandom_range(1, 8)), 8'($urandom_range(0, 255)), 1'b0, 0);
        run_phase(rand_name(), 4'd9, 8'd3, 1'b0, 0);

        drain(40);
        if (sb.expected_words.size() != 0) begin
            sb.errors++;
            $display("%0t: %0d result words expected, none arrived",
                     $time, sb.expected_words.size());
        end
        $display("run: %0d body words over %0d register settings, %0d bodies closed",
                 items_sent, settings_used, sb.bodies_closed);
        $display("run: %0d bodies held the field, %0d result words checked, %0d errors",
                 sb.bodies_found, sb.results_seen, sb.errors);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== form_field_extractor.f =====
hw/rtl/ffe_pkg.sv
hw/rtl/ffe_core.sv
hw/rtl/ffe_out_fifo.sv
hw/rtl/form_field_extractor.sv
verif/form_field_extractor_tb.sv
